### rtl/hgv_pkg.sv
// ----------------------------------------------------------------------------
// hgv_pkg
// Types, constants and helpers shared by the height grid text validator.
// ----------------------------------------------------------------------------
`default_nettype none

package hgv_pkg;

   localparam int COUNT_BITS     = 12;
   localparam int MAX_HEX_DIGITS = 8;
   localparam int HEX_RUN_BITS   = $clog2(MAX_HEX_DIGITS + 1);
   localparam int OUT_BITS       = 12;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;

   typedef enum logic [1:0] {
      CMD_CHAR = 2'd0,
      CMD_EOL  = 2'd1,
      CMD_EOF  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      CLS_ZERO   = 4'd0,
      CLS_DIGIT  = 4'd1,
      CLS_HEXLET = 4'd2,
      CLS_XCHAR  = 4'd3,
      CLS_SPACE  = 4'd4,
      CLS_MINUS  = 4'd5,
      CLS_COMMA  = 4'd6,
      CLS_TERM   = 4'd7,
      CLS_OTHER  = 4'd8
   } class_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_ONE     = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      PH_BETWEEN = 6'b000001,
      PH_MINUS   = 6'b000010,
      PH_DIGITS  = 6'b000100,
      PH_COMMA   = 6'b001000,
      PH_COMMA0  = 6'b010000,
      PH_HEX     = 6'b100000
   } phase_type;

   typedef struct packed {
      cmd_type   cmd;
      class_type cls;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } slot_type;

   function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] value);
      return OUT_BITS'(value);
   endfunction

endpackage

`default_nettype wire

### rtl/hgv_front.sv
// ----------------------------------------------------------------------------
// hgv_front
// Accepts items and classifies each text byte for the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module hgv_front
   import hgv_pkg::*;
(
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   output slot_type        push
);

   class_type cls;

   always_comb begin
      if (req_ch == CHAR_NUL || req_ch == CHAR_LF) begin
         cls = CLS_TERM;
      end else if (req_ch == CHAR_ZERO) begin
         cls = CLS_ZERO;
      end else if (req_ch > CHAR_ZERO && req_ch <= CHAR_NINE) begin
         cls = CLS_DIGIT;
      end else if ((req_ch >= CHAR_UP_A && req_ch <= CHAR_UP_F) ||
                   (req_ch >= CHAR_LO_A && req_ch <= CHAR_LO_F)) begin
         cls = CLS_HEXLET;
      end else if (req_ch == CHAR_LO_X) begin
         cls = CLS_XCHAR;
      end else if (req_ch == CHAR_SPACE) begin
         cls = CLS_SPACE;
      end else if (req_ch == CHAR_MINUS) begin
         cls = CLS_MINUS;
      end else if (req_ch == CHAR_COMMA) begin
         cls = CLS_COMMA;
      end else begin
         cls = CLS_OTHER;
      end
   end

   // drop the unused command
   always_comb begin
      push.item.cmd = cmd_type'(req_cmd);
      push.item.cls = cls;
      push.valid    = req_valid && !req_stall && (cmd_type'(req_cmd) != CMD_NONE);
   end

endmodule

`default_nettype wire

### rtl/hgv_queue.sv
// ----------------------------------------------------------------------------
// hgv_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hgv_queue
   import hgv_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  slot_type  push,
   input  wire logic pop,
   output slot_type  head,
   output logic      full
);

   item_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_pop;

   function automatic logic [QUEUE_PTR_BITS-1:0] next_ptr(input logic [QUEUE_PTR_BITS-1:0] p);
      if (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QUEUE_PTR_BITS'(1);
   endfunction

   always_comb begin
      head.valid = (count_ff != '0);
      head.item  = entry_ff[rd_ptr_ff];
      full       = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
      do_pop     = pop && head.valid;
      wr_ptr_in  = push.valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

### rtl/hgv_back.sv
// ----------------------------------------------------------------------------
// hgv_back
// Line scanner, file verdict and registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hgv_back
   import hgv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  slot_type                 head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_kind,
   output logic                     rsp_line_ok,
   output logic [OUT_BITS-1:0]      rsp_tokens,
   output logic [1:0]               rsp_status,
   output logic [OUT_BITS-1:0]      rsp_grid_width,
   output logic [OUT_BITS-1:0]      rsp_grid_rows
);

   phase_type                 phase_ff, phase_in;
   logic [HEX_RUN_BITS-1:0]   hex_run_ff, hex_run_in;
   logic [COUNT_BITS-1:0]     line_tokens_ff, line_tokens_in;
   logic                      line_failed_ff, line_failed_in;
   logic                      line_stopped_ff, line_stopped_in;
   logic [COUNT_BITS-1:0]     first_width_ff, first_width_in;
   logic [COUNT_BITS-1:0]     row_count_ff, row_count_in;
   logic                      on_first_ff, on_first_in;
   logic                      file_bad_ff, file_bad_in;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_kind_ff, out_kind_in;
   logic                      out_ok_ff, out_ok_in;
   logic [OUT_BITS-1:0]       out_tokens_ff, out_tokens_in;
   status_type                out_status_ff, out_status_in;
   logic [OUT_BITS-1:0]       out_width_ff, out_width_in;
   logic [OUT_BITS-1:0]       out_rows_ff, out_rows_in;

   logic                      is_char;
   logic                      is_result;
   logic                      pending;
   logic                      bad;
   logic                      ok;
   logic [COUNT_BITS-1:0]     tok;
   logic                      separator;
   logic                      is_dec;
   logic                      is_hex;
   status_type                verdict;

   always_comb begin
      is_char   = (head.item.cmd == CMD_CHAR);
      is_result = (head.item.cmd == CMD_EOL) || (head.item.cmd == CMD_EOF);
      pop       = head.valid && (is_char || !out_valid_ff || !rsp_stall);
      pending   = (phase_ff == PH_MINUS) || (phase_ff == PH_COMMA) ||
                  (phase_ff == PH_COMMA0);
      is_dec    = (head.item.cls == CLS_ZERO) || (head.item.cls == CLS_DIGIT);
      is_hex    = is_dec || (head.item.cls == CLS_HEXLET);
      bad       = line_failed_ff || pending;
      tok       = bad ? '0 : line_tokens_ff;
   end

   always_comb begin
      phase_in        = phase_ff;
      hex_run_in      = hex_run_ff;
      line_tokens_in  = line_tokens_ff;
      line_failed_in  = line_failed_ff;
      line_stopped_in = line_stopped_ff;
      first_width_in  = first_width_ff;
      row_count_in    = row_count_ff;
      on_first_in     = on_first_ff;
      file_bad_in     = file_bad_ff;
      separator       = 1'b0;
      ok              = 1'b0;
      verdict         = STATUS_OK;

      if (file_bad_ff) begin
         verdict = STATUS_INVALID;
      end else if (first_width_ff > COUNT_BITS'(1)) begin
         verdict = STATUS_OK;
      end else if (first_width_ff == COUNT_BITS'(1)) begin
         verdict = STATUS_ONE;
      end else begin
         verdict = STATUS_EMPTY;
      end

      if (pop) begin
         case (head.item.cmd)
            CMD_CHAR: begin
               if (!line_failed_ff && !line_stopped_ff) begin
                  if (head.item.cls == CLS_TERM) begin
                     if (pending) begin
                        line_failed_in = 1'b1;
                     end else begin
                        line_stopped_in = 1'b1;
                     end
                  end else begin
                     case (phase_ff)
                        PH_MINUS: begin
                           if (is_dec) begin
                              if (line_tokens_ff != COUNT_MAX) begin
                                 line_tokens_in = line_tokens_ff + COUNT_BITS'(1);
                              end
                              phase_in = PH_DIGITS;
                           end else begin
                              line_failed_in = 1'b1;
                           end
                        end
                        PH_COMMA: begin
                           if (head.item.cls == CLS_ZERO) begin
                              phase_in = PH_COMMA0;
                           end else begin
                              line_failed_in = 1'b1;
                           end
                        end
                        PH_COMMA0: begin
                           if (head.item.cls == CLS_XCHAR) begin
                              phase_in   = PH_HEX;
                              hex_run_in = '0;
                           end else begin
                              line_failed_in = 1'b1;
                           end
                        end
                        PH_DIGITS: begin
                           if (head.item.cls == CLS_COMMA) begin
                              phase_in = PH_COMMA;
                           end else if (!is_dec) begin
                              separator = 1'b1;
                           end
                        end
                        PH_HEX: begin
                           if (is_hex) begin
                              if (hex_run_ff >= HEX_RUN_BITS'(MAX_HEX_DIGITS)) begin
                                 line_failed_in = 1'b1;
                              end else begin
                                 hex_run_in = hex_run_ff + HEX_RUN_BITS'(1);
                              end
                           end else begin
                              separator = 1'b1;
                           end
                        end
                        default: begin
                           if (is_dec) begin
                              if (line_tokens_ff != COUNT_MAX) begin
                                 line_tokens_in = line_tokens_ff + COUNT_BITS'(1);
                              end
                              phase_in = PH_DIGITS;
                           end else begin
                              separator = 1'b1;
                           end
                        end
                     endcase
                     if (separator) begin
                        if (head.item.cls == CLS_SPACE) begin
                           phase_in = PH_BETWEEN;
                        end else if (head.item.cls == CLS_MINUS) begin
                           phase_in = PH_MINUS;
                        end else begin
                           line_failed_in = 1'b1;
                        end
                     end
                  end
               end
            end
            CMD_EOL: begin
               if (on_first_ff) begin
                  first_width_in = tok;
                  on_first_in    = 1'b0;
                  ok             = !bad;
                  if (row_count_ff != COUNT_MAX) begin
                     row_count_in = row_count_ff + COUNT_BITS'(1);
                  end
               end else if (file_bad_ff) begin
                  ok = !bad && (tok == first_width_ff);
               end else if (tok != first_width_ff) begin
                  file_bad_in = 1'b1;
               end else begin
                  ok = !bad;
                  if (row_count_ff != COUNT_MAX) begin
                     row_count_in = row_count_ff + COUNT_BITS'(1);
                  end
               end
               phase_in        = PH_BETWEEN;
               hex_run_in      = '0;
               line_tokens_in  = '0;
               line_failed_in  = 1'b0;
               line_stopped_in = 1'b0;
            end
            CMD_EOF: begin
               phase_in        = PH_BETWEEN;
               hex_run_in      = '0;
               line_tokens_in  = '0;
               line_failed_in  = 1'b0;
               line_stopped_in = 1'b0;
               first_width_in  = '0;
               row_count_in    = '0;
               on_first_in     = 1'b1;
               file_bad_in     = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // result stage: hold while stalled, load on a reporting item
   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_ok_in     = out_ok_ff;
      out_tokens_in = out_tokens_ff;
      out_status_in = out_status_ff;
      out_width_in  = out_width_ff;
      out_rows_in   = out_rows_ff;
      if (pop && is_result) begin
         out_valid_in = 1'b1;
         out_width_in = to_out(first_width_in);
         out_rows_in  = to_out(row_count_in);
         if (head.item.cmd == CMD_EOF) begin
            out_kind_in   = 1'b1;
            out_ok_in     = 1'b0;
            out_tokens_in = '0;
            out_status_in = verdict;
            out_width_in  = to_out(first_width_ff);
            out_rows_in   = to_out(row_count_ff);
         end else begin
            out_kind_in   = 1'b0;
            out_ok_in     = ok;
            out_tokens_in = to_out(tok);
            out_status_in = file_bad_in ? STATUS_INVALID : STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_BETWEEN;
         hex_run_ff      <= '0;
         line_tokens_ff  <= '0;
         line_failed_ff  <= 1'b0;
         line_stopped_ff <= 1'b0;
         first_width_ff  <= '0;
         row_count_ff    <= '0;
         on_first_ff     <= 1'b1;
         file_bad_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         hex_run_ff      <= hex_run_in;
         line_tokens_ff  <= line_tokens_in;
         line_failed_ff  <= line_failed_in;
         line_stopped_ff <= line_stopped_in;
         first_width_ff  <= first_width_in;
         row_count_ff    <= row_count_in;
         on_first_ff     <= on_first_in;
         file_bad_ff     <= file_bad_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_ok_ff     <= out_ok_in;
      out_tokens_ff <= out_tokens_in;
      out_status_ff <= out_status_in;
      out_width_ff  <= out_width_in;
      out_rows_ff   <= out_rows_in;
   end

   always_comb begin
      rsp_valid      = out_valid_ff;
      rsp_kind       = out_kind_ff;
      rsp_line_ok    = out_ok_ff;
      rsp_tokens     = out_tokens_ff;
      rsp_status     = out_status_ff;
      rsp_grid_width = out_width_ff;
      rsp_grid_rows  = out_rows_ff;
   end

endmodule

`default_nettype wire

### rtl/height_grid_text_validator_core.sv
// ----------------------------------------------------------------------------
// height_grid_text_validator_core
// Byte-serial checker for text height maps: per-line and end-of-file reports.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_cmd, req_ch
//  rsp      out        rsp_valid / rsp_stall  rsp_kind, rsp_line_ok, rsp_tokens,
//                                             rsp_status, rsp_grid_width, rsp_grid_rows
//
//  One item per cycle while req_stall is low; the scanner registers its line state per item.
//  An end-of-line or end-of-file item passes the queue, then the registered result stage.
//  A two-entry item queue separates the classifier from the scanner.
//  req_stall rises only when the queue is full, i.e. after rsp_stall has held a result.
//  Synchronous reset returns the scanner to the start of a file.
// ----------------------------------------------------------------------------
`default_nettype none

module height_grid_text_validator_core
   import hgv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [7:0]          req_ch,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_kind,
   output logic                     rsp_line_ok,
   output logic [OUT_BITS-1:0]      rsp_tokens,
   output logic [1:0]               rsp_status,
   output logic [OUT_BITS-1:0]      rsp_grid_width,
   output logic [OUT_BITS-1:0]      rsp_grid_rows
);

   slot_type push;
   slot_type head;
   logic     pop;
   logic     full;

   assign req_stall = full;

   hgv_front u_front (
      .req_cmd   (req_cmd),
      .req_ch    (req_ch),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .push      (push)
   );

   hgv_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   hgv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_line_ok    (rsp_line_ok),
      .rsp_tokens     (rsp_tokens),
      .rsp_status     (rsp_status),
      .rsp_grid_width (rsp_grid_width),
      .rsp_grid_rows  (rsp_grid_rows)
   );

   a_file_report_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> !rsp_line_ok && (rsp_tokens == '0))
      else $error("file report carries line fields");

   a_ok_matches_width : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind && rsp_line_ok |-> rsp_tokens == rsp_grid_width)
      else $error("valid line differs from grid width");

   a_stall_means_queued : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> head.valid && rsp_valid)
      else $error("input stalled with room downstream");

endmodule

`default_nettype wire

### sim/tb_height_grid_text_validator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_height_grid_text_validator_core
// Self-checking bench for the height grid text validator. A queue of text
// bytes and line/file commands feeds a clocked driver. A clocked monitor
// predicts each line and file report, and checks every report the block
// returns against the oldest prediction. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_height_grid_text_validator_core;
   import hgv_pkg::*;

   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int SHOW_LIMIT    = 10;

   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_FILE = 1'b1;

   typedef struct packed {
      logic                kind;
      logic                line_ok;
      logic [OUT_BITS-1:0] tokens;
      logic [1:0]          status;
      logic [OUT_BITS-1:0] width;
      logic [OUT_BITS-1:0] rows;
   } grid_report_type;

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] ch;
      bit         drain;
   } feed_entry_type;

   typedef enum {
      FLAW_NONE,
      FLAW_WIDER,
      FLAW_NARROWER,
      FLAW_JUNK,
      FLAW_TAIL,
      FLAW_STOP,
      FLAW_STOP_PENDING,
      FLAW_NOISE
   } line_flaw_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_cmd   = 2'd0;
   logic [7:0]          req_ch    = 8'd0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_kind;
   logic                rsp_line_ok;
   logic [OUT_BITS-1:0] rsp_tokens;
   logic [1:0]          rsp_status;
   logic [OUT_BITS-1:0] rsp_grid_width;
   logic [OUT_BITS-1:0] rsp_grid_rows;

   height_grid_text_validator_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_line_ok    (rsp_line_ok),
      .rsp_tokens     (rsp_tokens),
      .rsp_status     (rsp_status),
      .rsp_grid_width (rsp_grid_width),
      .rsp_grid_rows  (rsp_grid_rows)
   );

   feed_entry_type  byte_feed[$];
   grid_report_type pending_reports[$];
   grid_report_type predicted, seen, wanted;
   feed_entry_type  head;

   int items_queued = 0;
   int items_taken  = 0;
   int gen_count    = 0;
   int fail_count   = 0;
   int cycle_count  = 0;
   int send_gap_pct = 0;
   int rsp_gap_pct  = 0;
   int gap_left     = 0;
   int stall_left   = 0;
   int hold_left    = 0;
   bit long_hold_go = 1'b0;
   bit req_taken    = 1'b0;

   // ------------------------------------------------------------------------
   // Line and file state of the scanner
   // ------------------------------------------------------------------------
   phase_type             line_phase     = PH_BETWEEN;
   int                    color_digits   = 0;
   logic [COUNT_BITS-1:0] line_count     = '0;
   bit                    line_broken    = 1'b0;
   bit                    line_done      = 1'b0;
   logic [COUNT_BITS-1:0] map_width      = '0;
   logic [COUNT_BITS-1:0] map_rows       = '0;
   bit                    first_row_open = 1'b1;
   bit                    map_bad        = 1'b0;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function bit lookahead_open();
      return line_phase == PH_MINUS || line_phase == PH_COMMA || line_phase == PH_COMMA0;
   endfunction

   function void open_token();
      line_count = sat_inc(line_count);
      line_phase = PH_DIGITS;
   endfunction

   function void clear_line();
      line_phase   = PH_BETWEEN;
      color_digits = 0;
      line_count   = '0;
      line_broken  = 1'b0;
      line_done    = 1'b0;
   endfunction

   function void scan_char(input logic [7:0] c);
      if (line_broken || line_done) return;
      if (c == CHAR_NUL || c == CHAR_LF) begin
         if (lookahead_open()) line_broken = 1'b1;
         else line_done = 1'b1;
         return;
      end
      case (line_phase)
         PH_MINUS: begin
            if (is_digit(c)) open_token();
            else line_broken = 1'b1;
            return;
         end
         PH_COMMA: begin
            if (c == CHAR_ZERO) line_phase = PH_COMMA0;
            else line_broken = 1'b1;
            return;
         end
         PH_COMMA0: begin
            if (c == CHAR_LO_X) begin
               line_phase   = PH_HEX;
               color_digits = 0;
            end else begin
               line_broken = 1'b1;
            end
            return;
         end
         PH_DIGITS: begin
            if (is_digit(c)) return;
            if (c == CHAR_COMMA) begin
               line_phase = PH_COMMA;
               return;
            end
         end
         PH_HEX: begin
            if (is_digit(c) || (c >= CHAR_UP_A && c <= CHAR_UP_F) ||
                (c >= CHAR_LO_A && c <= CHAR_LO_F)) begin
               if (color_digits >= MAX_HEX_DIGITS) line_broken = 1'b1;
               else color_digits++;
               return;
            end
         end
         default: begin
            if (is_digit(c)) begin
               open_token();
               return;
            end
         end
      endcase
      // only a space or a minus may end a token or stand between tokens
      if (c == CHAR_SPACE) line_phase = PH_BETWEEN;
      else if (c == CHAR_MINUS) line_phase = PH_MINUS;
      else line_broken = 1'b1;
   endfunction

   function bit next_report(input logic [1:0] cmd, input logic [7:0] ch,
                            output grid_report_type rep);
      bit                    bad;
      logic [COUNT_BITS-1:0] tok;
      rep = '0;
      case (cmd)
         CMD_CHAR: begin
            scan_char(ch);
            return 1'b0;
         end
         CMD_EOL: begin
            bad = line_broken || lookahead_open();
            tok = bad ? '0 : line_count;
            if (first_row_open) begin
               map_width      = tok;
               first_row_open = 1'b0;
               rep.line_ok    = !bad;
               map_rows       = sat_inc(map_rows);
            end else if (map_bad) begin
               rep.line_ok = !bad && tok == map_width;
            end else if (tok != map_width) begin
               map_bad     = 1'b1;
               rep.line_ok = 1'b0;
            end else begin
               rep.line_ok = !bad;
               map_rows    = sat_inc(map_rows);
            end
            rep.kind   = KIND_LINE;
            rep.tokens = OUT_BITS'(tok);
            rep.status = map_bad ? STATUS_INVALID : STATUS_OK;
            rep.width  = OUT_BITS'(map_width);
            rep.rows   = OUT_BITS'(map_rows);
            clear_line();
            return 1'b1;
         end
         CMD_EOF: begin
            rep.kind = KIND_FILE;
            if (map_bad) rep.status = STATUS_INVALID;
            else if (map_width > 1) rep.status = STATUS_OK;
            else if (map_width == 1) rep.status = STATUS_ONE;
            else rep.status = STATUS_EMPTY;
            rep.width      = OUT_BITS'(map_width);
            rep.rows       = OUT_BITS'(map_rows);
            clear_line();
            map_width      = '0;
            map_rows       = '0;
            first_row_open = 1'b1;
            map_bad        = 1'b0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------
   task automatic put(input logic [1:0] cmd, input logic [7:0] ch);
      byte_feed.push_back('{cmd, ch, 1'b0});
      items_queued++;
      if (cmd != CMD_NONE) gen_count++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(CMD_CHAR, s[i]);
   endtask

   task automatic fill_random(input int n);
      int            target;
      int            width;
      int            rows;
      int            count;
      int            digits;
      bit            neg;
      line_flaw_type flaw;
      string         hex_set;
      hex_set = "0123456789abcdefABCDEF";
      target  = gen_count + n;
      while (gen_count < target) begin
         width = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
         rows  = $urandom_range(0, 5);
         for (int r = 0; r < rows; r++) begin
            flaw  = ($urandom_range(0, 2) != 0) ? FLAW_NONE :
                    line_flaw_type'($urandom_range(1, 7));
            count = width;
            if (flaw == FLAW_WIDER) count = width + 1;
            if (flaw == FLAW_NARROWER && width > 0) count = width - 1;
            if ($urandom_range(0, 4) == 0) put(CMD_CHAR, CHAR_SPACE);
            for (int t = 0; t < count; t++) begin
               neg = ($urandom_range(0, 3) == 0);
               if (t > 0 && !(neg && $urandom_range(0, 1) == 0)) put(CMD_CHAR, CHAR_SPACE);
               if (neg) put(CMD_CHAR, CHAR_MINUS);
               repeat ($urandom_range(1, 3)) put(CMD_CHAR, CHAR_ZERO + 8'($urandom_range(0, 9)));
               if ($urandom_range(0, 3) == 0) begin
                  put_text(",0x");
                  digits = ($urandom_range(0, 7) == 0) ? MAX_HEX_DIGITS + 1 :
                           $urandom_range(0, MAX_HEX_DIGITS);
                  repeat (digits) put(CMD_CHAR, hex_set[$urandom_range(0, 21)]);
               end
            end
            case (flaw)
               FLAW_JUNK: put(CMD_CHAR, 8'($urandom_range(0, 255)));
               FLAW_TAIL: begin
                  case ($urandom_range(0, 2))
                     0: put_text("-");
                     1: put_text(",");
                     default: put_text(",0");
                  endcase
                  if ($urandom_range(0, 1) == 0) put(CMD_CHAR, 8'($urandom_range(0, 255)));
               end
               FLAW_STOP: begin
                  put(CMD_CHAR, $urandom_range(0, 1) ? CHAR_NUL : CHAR_LF);
                  put(CMD_CHAR, 8'($urandom_range(0, 255)));
               end
               FLAW_STOP_PENDING: begin
                  put(CMD_CHAR, CHAR_MINUS);
                  put(CMD_CHAR, $urandom_range(0, 1) ? CHAR_NUL : CHAR_LF);
               end
               FLAW_NOISE: put(CMD_NONE, 8'($urandom_range(0, 255)));
               default: ;
            endcase
            if ($urandom_range(0, 5) == 0) put(CMD_CHAR, CHAR_SPACE);
            put(CMD_EOL, 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 5) == 0) put_text("12");
         put(CMD_EOF, 8'($urandom_range(0, 255)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock, driver, receiver, monitor
   // ------------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled item
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (byte_feed.size() == 0) begin
         req_valid <= 1'b0;
      end else if (byte_feed[0].drain) begin
         req_valid <= 1'b0;
         if (pending_reports.size() == 0) void'(byte_feed.pop_front());
      end else if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
         gap_left = $urandom_range(1, 13) - 1;
         req_valid <= 1'b0;
      end else begin
         head = byte_feed.pop_front();
         req_valid <= 1'b1;
         req_cmd   <= head.cmd;
         req_ch    <= head.ch;
      end
   end

   always @(negedge clock) begin
      if (long_hold_go) begin
         long_hold_go = 1'b0;
         hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_gap_pct > 0 && $urandom_range(0, 99) < rsp_gap_pct) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            items_taken++;
            if (next_report(req_cmd, req_ch, predicted)) pending_reports.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_kind, rsp_line_ok, rsp_tokens, rsp_status, rsp_grid_width,
                    rsp_grid_rows};
            if (pending_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT)
                  $display("unexpected report: kind %0d ok %0d tok %0d st %0d w %0d r %0d",
                           seen.kind, seen.line_ok, seen.tokens, seen.status, seen.width,
                           seen.rows);
            end else begin
               wanted = pending_reports.pop_front();
               if (seen !== wanted) begin
                  fail_count++;
                  if (fail_count <= SHOW_LIMIT) begin
                     $write("report mismatch: exp kind %0d ok %0d tok %0d st %0d w %0d r %0d,",
                            wanted.kind, wanted.line_ok, wanted.tokens, wanted.status,
                            wanted.width, wanted.rows);
                     $display(" got kind %0d ok %0d tok %0d st %0d w %0d r %0d",
                              seen.kind, seen.line_ok, seen.tokens, seen.status, seen.width,
                              seen.rows);
                  end
               end
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: chained tokens, empty colour, bad minus, stop byte, unused command,
      // unterminated line, empty file, one tile
      send_gap_pct = 20;
      rsp_gap_pct  = 20;
      put_text("1-2,0x 3");
      put(CMD_EOL, 8'hFF);
      put_text("-a");
      put(CMD_EOL, 8'h00);
      put(CMD_NONE, 8'hFF);
      put_text("7 ");
      put(CMD_CHAR, CHAR_NUL);
      put(CMD_CHAR, 8'hFF);
      put(CMD_EOL, 8'hAA);
      put_text("4");
      put(CMD_EOF, 8'h55);
      put(CMD_EOF, 8'h00);
      put_text("5");
      put(CMD_EOL, 8'h00);
      put(CMD_EOF, 8'hFF);
      wait (items_taken == items_queued);

      // back-pressure: long receiver hold while the sender keeps offering
      gen_count    = 0;
      send_gap_pct = 0;
      rsp_gap_pct  = 0;
      long_hold_go = 1'b1;
      fill_random(150);
      byte_feed.push_back('{CMD_CHAR, 8'h00, 1'b1});
      fill_random(60);
      wait (items_taken == items_queued);

      send_gap_pct = 20;
      rsp_gap_pct  = 20;
      fill_random(200);
      wait (items_taken == items_queued);

      send_gap_pct = 0;
      rsp_gap_pct  = 0;
      fill_random(100);
      wait (items_taken == items_queued);

      send_gap_pct = 10;
      rsp_gap_pct  = 35;
      fill_random(150);
      wait (items_taken == items_queued);

      send_gap_pct = 0;
      rsp_gap_pct  = 0;
      fill_random(110);
      wait (items_taken == items_queued);

      wait (pending_reports.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/hgv_pkg.sv
rtl/hgv_front.sv
rtl/hgv_queue.sv
rtl/hgv_back.sv
rtl/height_grid_text_validator_core.sv
sim/tb_height_grid_text_validator_core.sv
